>>> hw/rtl/gpx_pkg.sv
// Shared types, constants and helpers for the GPX track point CSV extractor.
package gpx_pkg;

    localparam int VALUE_DEPTH_DEF = 24;
    localparam int TAG_DEPTH_DEF   = 8;
    localparam int NAME_DEPTH      = 4;
    localparam int MAX_RESULTS     = 50;

    // drain sources, in emission order
    typedef enum logic [2:0] {
        SRC_LAT,
        SRC_LON,
        SRC_ELE,
        SRC_TIME,
        SRC_NONE
    } t_src;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic step;      // update parse state with the held item
        logic load;      // fetch next burst byte into output register
        t_src src;       // buffer that is being drained
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [3:0] pend;   // one bit per source with a burst owed
        logic       done;   // current source fully fetched
    } t_sts;

    function automatic logic [7:0] upcase(input logic [7:0] b);
        upcase = (b >= 8'h61 && b <= 8'h7a) ? b - 8'd32 : b;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        is_ws = (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
    endfunction

endpackage

>>> hw/rtl/gpx_trackpoint_csv_extractor_unit.sv
// GPX track point extractor: one GPX byte in per item, CSV bytes out.
// Each input item is parsed in ST_IDLE and settles in ST_DRAIN, then every
// CSV byte it releases goes through the single output register, read one
// byte a cycle from the value buffers while the receiver does not stall: a
// closing character releases a burst (lat and lon trimmed of quotes plus a
// comma each, ele plus a comma, time plus a newline, at most 50 bytes per
// item); other characters release none. The last byte of a burst waits in
// the output register while the next item is parsed.
module gpx_trackpoint_csv_extractor_unit #(
    parameter int VALUE_DEPTH = gpx_pkg::VALUE_DEPTH_DEF,
    parameter int TAG_DEPTH   = gpx_pkg::TAG_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_escape_comma,
    output logic       o_last
);
    import gpx_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic last_src;

    gpx_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .o_cmd(cmd), .i_sts(sts),
        .o_last_src(last_src)
    );

    gpx_dp #(.VALUE_DEPTH(VALUE_DEPTH), .TAG_DEPTH(TAG_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_char(i_in_char), .i_cmd(cmd),
        .i_last_src(last_src), .o_sts(sts), .o_char(o_out_char),
        .o_esc(o_escape_comma), .o_last(o_last)
    );
endmodule

>>> hw/rtl/gpx_ctrl.sv
// Controller: sequences parse step and the byte bursts of each buffer.
module gpx_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output gpx_pkg::t_cmd o_cmd,
    input  gpx_pkg::t_sts i_sts,
    output logic          o_last_src
);
    import gpx_pkg::*;

    localparam int CW = $clog2(MAX_RESULTS);

    t_state r_state, n_state;
    t_src   r_src, n_src;
    logic   r_ovalid, n_ovalid;
    logic [3:0] r_pend, n_pend;
    logic [CW-1:0] r_cnt, n_cnt;    // items loaded for the current input item
    logic       cap;

    function automatic t_src first_src(input logic [3:0] p);
        if (p[0]) return SRC_LAT;
        if (p[1]) return SRC_LON;
        if (p[2]) return SRC_ELE;
        if (p[3]) return SRC_TIME;
        return SRC_NONE;
    endfunction

    // burst is cut after the last allowed item
    assign cap = (r_cnt == CW'(MAX_RESULTS - 1));

    // state and burst bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_src    <= SRC_NONE;
            r_ovalid <= 1'b0;
            r_pend   <= '0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_src    <= n_src;
            r_ovalid <= n_ovalid;
            r_pend   <= n_pend;
            r_cnt    <= n_cnt;
        end
    end

    logic       take;
    logic [3:0] rest;
    always_comb begin
        n_state  = r_state;
        n_src    = r_src;
        n_pend   = r_pend;
        n_ovalid = r_ovalid;
        n_cnt    = r_cnt;
        o_cmd    = '{step: 1'b0, load: 1'b0, src: r_src};
        take     = r_ovalid && !i_stall;
        rest     = '0;
        if (take) n_ovalid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // the output register keeps the last byte while the next item parses
                if (i_valid) begin
                    o_cmd.step = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // pick up the pending set latched by the step
                n_pend = i_sts.pend;
                n_src  = first_src(i_sts.pend);
                n_state = (i_sts.pend == '0) ? ST_IDLE : ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || take) begin
                    o_cmd.load = 1'b1;
                    n_ovalid   = 1'b1;
                    n_cnt      = r_cnt + 1'b1;
                    if (cap) begin
                        n_pend  = '0;
                        n_state = ST_IDLE;
                    end else if (i_sts.done) begin
                        rest = r_pend;
                        rest[r_src[1:0]] = 1'b0;
                        n_pend = rest;
                        n_src  = first_src(rest);
                        if (rest == '0) n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_ovalid;
    assign o_last_src = cap ||
                        (i_sts.done && ((r_pend & ~(4'b1 << r_src[1:0])) == '0));

    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == ST_OUT) else $error("load outside drain");
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |=> r_state == ST_DRAIN) else $error("step did not drain");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> r_ovalid) else $error("output item lost");
endmodule

>>> hw/rtl/gpx_dp.sv
// Datapath: parse state, name compare, value buffers and output byte register.
module gpx_dp #(
    parameter int VALUE_DEPTH = gpx_pkg::VALUE_DEPTH_DEF,
    parameter int TAG_DEPTH   = gpx_pkg::TAG_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_char,
    input  gpx_pkg::t_cmd i_cmd,
    input  logic          i_last_src,
    output gpx_pkg::t_sts o_sts,
    output logic [7:0]    o_char,
    output logic          o_esc,
    output logic          o_last
);
    import gpx_pkg::*;

    localparam int VW = $clog2(VALUE_DEPTH + 1);
    localparam int VI = $clog2(VALUE_DEPTH);
    localparam int TW = $clog2(TAG_DEPTH + 1);
    localparam int TI = $clog2(TAG_DEPTH);
    localparam int NW = $clog2(NAME_DEPTH + 1);
    localparam int NI = $clog2(NAME_DEPTH);

    logic       r_qopen, r_treading, r_held, r_trk, r_ele, r_time, r_epos, r_tpos;
    logic [7:0] r_qchar;
    logic [TW-1:0] r_tlen;
    logic [1:0] r_latph, r_lonph;
    logic [NW-1:0] r_latnl, r_lonnl;
    logic [7:0] r_tag [TAG_DEPTH];
    logic [7:0] r_latn [NAME_DEPTH];
    logic [7:0] r_lonn [NAME_DEPTH];
    logic [VW-1:0] r_len [4];
    logic [7:0] mem_lat [VALUE_DEPTH];
    logic [7:0] mem_lon [VALUE_DEPTH];
    logic [7:0] mem_ele [VALUE_DEPTH];
    logic [7:0] mem_tim [VALUE_DEPTH];
    logic [3:0] r_pend;
    logic [VW-1:0] r_dlen [4];      // lengths snapshot for the burst
    logic [VW:0]   r_pos;           // bytes of the current source already sent
    logic [7:0] r_och;
    logic       r_oesc, r_olast;

    // full-length case-insensitive compare of the tag against a literal
    function automatic logic tag_is(input logic [8*6-1:0] lit, input int n,
                                    input logic [7:0] t [TAG_DEPTH],
                                    input logic [TW-1:0] len);
        logic ok;
        ok = (int'(len) == n);
        for (int k = 0; k < 6; k++)
            if (k < n && k < TAG_DEPTH && upcase(t[k]) != lit[8*(n-1-k) +: 8]) ok = 1'b0;
        return ok;
    endfunction

    function automatic logic name_is(input logic [23:0] lit,
                                     input logic [7:0] t [NAME_DEPTH],
                                     input logic [NW-1:0] len);
        logic ok;
        ok = (len == NW'(3));
        for (int k = 0; k < 3; k++)
            if (upcase(t[k]) != upcase(lit[8*(2-k) +: 8])) ok = 1'b0;
        return ok;
    endfunction

    logic [7:0] b;
    logic q, ws, gt, lt, eq;
    assign b  = i_char;
    assign q  = (b == 8'h22) || (b == 8'h27);
    assign ws = is_ws(b);
    assign gt = (b == 8'h3e);
    assign lt = (b == 8'h3c);
    assign eq = (b == 8'h3d);

    // sequential parse update
    always_ff @(posedge i_clk) begin
        logic qo, tr, hd, trk, el, tm, lo, lno;
        logic [TW-1:0] tl;
        logic [1:0] lp, np;
        logic [NW-1:0] lal, lol;
        logic [3:0] pd;
        logic [VW-1:0] ln [4];
        if (!i_rst_n) begin
            r_qopen <= 1'b0; r_qchar <= '0; r_treading <= 1'b0; r_held <= 1'b0;
            r_tlen <= '0; r_trk <= 1'b0; r_ele <= 1'b0; r_time <= 1'b0;
            r_epos <= 1'b0; r_tpos <= 1'b0; r_latph <= '0; r_lonph <= '0;
            r_latnl <= '0; r_lonnl <= '0; r_pend <= '0;
            for (int k = 0; k < 4; k++) r_len[k] <= '0;
        end else if (i_cmd.step) begin
            qo = r_qopen; tr = r_treading; hd = r_held; tl = r_tlen;
            trk = r_trk; el = r_ele; tm = r_time; lp = r_latph; np = r_lonph;
            lal = r_latnl; lol = r_lonnl; pd = '0;
            for (int k = 0; k < 4; k++) ln[k] = r_len[k];
            // quotes
            if (q && !qo) begin
                qo = 1'b1; r_qchar <= b;
            end else if (q && qo && b == r_qchar) begin
                qo = 1'b0; r_qchar <= '0;
            end
            // tag name
            if (lt) tr = 1'b1;
            else if (tr) begin
                if (!ws && !gt) begin
                    if (!hd && int'(tl) < TAG_DEPTH) begin
                        r_tag[tl[TI-1:0]] <= b; tl = tl + 1'b1;
                    end
                end else begin
                    if (tl != '0) hd = 1'b1;
                    tr = 1'b0;
                end
            end
            // tag commit; tag bytes written this cycle never matter here
            if ((ws || gt) && hd && !tr && !qo) begin
                if (tag_is("TRKPT", 5, r_tag, tl)) trk = 1'b1;
                else if (tag_is("/TRKPT", 6, r_tag, tl)) trk = 1'b0;
                else if (tag_is("ELE", 3, r_tag, tl)) el = 1'b1;
                else if (tag_is("/ELE", 4, r_tag, tl)) el = 1'b0;
                else if (tag_is("TIME", 4, r_tag, tl)) tm = 1'b1;
                else if (tag_is("/TIME", 5, r_tag, tl)) tm = 1'b0;
                tl = '0; hd = 1'b0;
            end
            // latitude
            lo = !qo && trk && lp == 2'd0 && !el && !tm;
            if (!ws && !eq && lo) begin
                if (int'(lal) < NAME_DEPTH) begin
                    r_latn[lal[NI-1:0]] <= b; lal = lal + 1'b1;
                end
            end else if ((ws || eq) && lo && lal != '0) begin
                if (name_is("lat", r_latn, lal)) lp = 2'd1;
                lal = '0;
            end else if ((q || qo) && trk && lp == 2'd1) begin
                if (int'(ln[0]) < VALUE_DEPTH) begin
                    mem_lat[ln[0][VI-1:0]] <= b; ln[0] = ln[0] + 1'b1;
                end
            end else if (ws && !qo && trk && lp == 2'd1 && ln[0] != '0) begin
                lp = 2'd2;
            end else if (gt && !qo && trk && lp == 2'd2) begin
                pd[0] = 1'b1; r_dlen[0] <= ln[0];
                ln[0] = '0; lp = 2'd0; lal = '0;
            end
            // longitude
            lno = !qo && trk && np == 2'd0 && !el && !tm;
            if (!ws && !eq && lno) begin
                if (int'(lol) < NAME_DEPTH) begin
                    r_lonn[lol[NI-1:0]] <= b; lol = lol + 1'b1;
                end
            end else if ((ws || eq) && lno && lol != '0) begin
                if (name_is("lon", r_lonn, lol)) np = 2'd1;
                lol = '0;
            end else if ((q || qo) && trk && np == 2'd1) begin
                if (int'(ln[1]) < VALUE_DEPTH) begin
                    mem_lon[ln[1][VI-1:0]] <= b; ln[1] = ln[1] + 1'b1;
                end
            end else if ((ws || gt) && !qo && trk && np == 2'd1 && ln[1] != '0) begin
                np = 2'd2;
            end
            if (gt && !qo && trk && np == 2'd2) begin
                pd[1] = 1'b1; r_dlen[1] <= ln[1];
                ln[1] = '0; np = 2'd0; lol = '0;
            end
            // elevation
            if (gt && !qo && trk && el) r_epos <= 1'b1;
            else if (!lt && r_epos) begin
                if (int'(ln[2]) < VALUE_DEPTH) begin
                    mem_ele[ln[2][VI-1:0]] <= b; ln[2] = ln[2] + 1'b1;
                end
            end else if (lt && r_epos) r_epos <= 1'b0;
            else if ((ws || gt) && trk && !el && ln[2] != '0) begin
                pd[2] = 1'b1; r_dlen[2] <= ln[2]; ln[2] = '0;
            end
            // time
            if (gt && !qo && trk && tm) r_tpos <= 1'b1;
            else if (!lt && r_tpos) begin
                if (int'(ln[3]) < VALUE_DEPTH) begin
                    mem_tim[ln[3][VI-1:0]] <= b; ln[3] = ln[3] + 1'b1;
                end
            end else if (lt && r_tpos) r_tpos <= 1'b0;
            else if ((ws || gt) && trk && !tm && ln[3] != '0) begin
                pd[3] = 1'b1; r_dlen[3] <= ln[3]; ln[3] = '0;
            end
            r_qopen <= qo; r_treading <= tr; r_held <= hd; r_tlen <= tl;
            r_trk <= trk; r_ele <= el; r_time <= tm; r_latph <= lp; r_lonph <= np;
            r_latnl <= lal; r_lonnl <= lol; r_pend <= pd;
            for (int k = 0; k < 4; k++) r_len[k] <= ln[k];
        end
    end

    // burst position: trimmed sources skip the opening and closing quote
    logic [VW:0] cnt, addr;
    logic [1:0]  si;
    logic        trim;
    assign si   = i_cmd.src[1:0];
    assign trim = (i_cmd.src == SRC_LAT) || (i_cmd.src == SRC_LON);
    always_comb begin
        cnt = {1'b0, r_dlen[si]};
        if (trim) cnt = (r_dlen[si] >= VW'(2)) ? cnt - (VW+1)'(2) : '0;
    end
    assign addr = r_pos + (VW+1)'(trim);
    // r_pos == cnt means the trailing separator is next
    assign o_sts.done = (r_pos >= cnt);
    assign o_sts.pend = r_pend;

    logic [7:0] rd;
    always_comb begin
        case (i_cmd.src)
            SRC_LAT:  rd = mem_lat[addr[VI-1:0]];
            SRC_LON:  rd = mem_lon[addr[VI-1:0]];
            SRC_ELE:  rd = mem_ele[addr[VI-1:0]];
            SRC_TIME: rd = mem_tim[addr[VI-1:0]];
            default:  rd = '0;
        endcase
    end

    // output byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pos <= '0;
        else if (i_cmd.step) r_pos <= '0;
        else if (i_cmd.load) begin
            r_olast <= i_last_src;
            if (o_sts.done) begin
                r_och  <= (i_cmd.src == SRC_TIME) ? 8'h0a : 8'h2c;
                r_oesc <= 1'b0;
                r_pos  <= '0;
            end else begin
                r_och  <= rd;
                r_oesc <= (i_cmd.src == SRC_TIME) && (rd == 8'h2c);
                r_pos  <= r_pos + 1'b1;
            end
        end
    end

    assign o_char = r_och;
    assign o_esc  = r_oesc;
    assign o_last = r_olast;

    a_tlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_tlen) <= TAG_DEPTH) else $error("tag length overrun");
    a_vlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_len[3]) <= VALUE_DEPTH) else $error("time length overrun");
    a_esc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oesc |-> r_och == 8'h2c) else $error("escape on non comma");
endmodule

>>> tb/tb_top.sv
// Testbench for the GPX track point CSV extractor: random GPX text against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VDEPTH = gpx_pkg::VALUE_DEPTH_DEF;
    localparam int TDEPTH = gpx_pkg::TAG_DEPTH_DEF;
    localparam int NDEPTH = gpx_pkg::NAME_DEPTH;
    localparam int MAXOUT = gpx_pkg::MAX_RESULTS;

    typedef struct packed {
        logic [7:0] ch;
        logic       esc;
        logic       last;
    } t_csv_byte;

    // Parser state mirror and expected CSV byte queue
    class t_scoreboard;
        bit         q_open;
        logic [7:0] q_char;
        bit         t_reading, t_held;
        logic [7:0] t_text[TDEPTH];
        int         t_len;
        bit         in_trk, in_ele, in_time, ele_pos, tm_pos;
        int         lat_ph, lon_ph;
        logic [7:0] lat_nm[NDEPTH], lon_nm[NDEPTH];
        int         lat_nl, lon_nl;
        logic [7:0] vals[4][VDEPTH];
        int         vlen[4];
        t_csv_byte  pending[$];
        t_csv_byte  burst[$];
        int         errors;

        function automatic logic [7:0] up(logic [7:0] b);
            return (b >= "a" && b <= "z") ? b - 8'd32 : b;
        endfunction

        // full-length case-insensitive compare
        function automatic bit matches_name(logic [7:0] buf_[], int len, string lit);
            if (len != lit.len()) return 0;
            for (int i = 0; i < len; i++)
                if (up(buf_[i]) != up(lit[i])) return 0;
            return 1;
        endfunction

        function void push(logic [7:0] b, bit e);
            t_csv_byte r;
            if (burst.size() >= MAXOUT) return;
            r.ch = b; r.esc = e; r.last = 0;
            burst.push_back(r);
        endfunction

        function void emit_trimmed(int s);
            for (int i = 1; i + 1 < vlen[s]; i++) push(vals[s][i], 0);
            push(",", 0);
        endfunction

        function void put_val(int s, logic [7:0] b);
            if (vlen[s] < VDEPTH) begin
                vals[s][vlen[s]] = b;
                vlen[s]++;
            end
        endfunction

        function void note_char(logic [7:0] b);
            bit q, ws, gt, lt, eq, lat_open, lon_open;
            logic [7:0] tt[], nm[];
            q  = (b == 8'h22 || b == 8'h27);
            ws = (b == " " || (b >= 9 && b <= 13));
            gt = (b == ">"); lt = (b == "<"); eq = (b == "=");
            burst.delete();
            // quote tracking
            if (q && !q_open) begin
                q_open = 1; q_char = b;
            end else if (q && q_open && b == q_char) begin
                q_open = 0; q_char = 0;
            end
            // tag name
            if (lt) begin
                t_reading = 1;
            end else if (t_reading) begin
                if (!ws && !gt) begin
                    if (!t_held && t_len < TDEPTH) begin
                        t_text[t_len] = b; t_len++;
                    end
                end else begin
                    if (t_len > 0) t_held = 1;
                    t_reading = 0;
                end
            end
            if ((ws || gt) && t_held && !t_reading && !q_open) begin
                tt = new[TDEPTH];
                foreach (t_text[i]) tt[i] = t_text[i];
                if (matches_name(tt, t_len, "TRKPT")) in_trk = 1;
                else if (matches_name(tt, t_len, "/TRKPT")) in_trk = 0;
                else if (matches_name(tt, t_len, "ELE")) in_ele = 1;
                else if (matches_name(tt, t_len, "/ELE")) in_ele = 0;
                else if (matches_name(tt, t_len, "TIME")) in_time = 1;
                else if (matches_name(tt, t_len, "/TIME")) in_time = 0;
                t_len = 0; t_held = 0;
            end
            // latitude
            lat_open = !q_open && in_trk && lat_ph == 0 && !in_ele && !in_time;
            if (!ws && !eq && lat_open) begin
                if (lat_nl < NDEPTH) begin lat_nm[lat_nl] = b; lat_nl++; end
            end else if ((ws || eq) && lat_open && lat_nl > 0) begin
                nm = new[NDEPTH];
                foreach (lat_nm[i]) nm[i] = lat_nm[i];
                if (matches_name(nm, lat_nl, "lat")) lat_ph = 1;
                lat_nl = 0;
            end else if ((q || q_open) && in_trk && lat_ph == 1) begin
                put_val(0, b);
            end else if (ws && !q_open && in_trk && lat_ph == 1 && vlen[0] > 0) begin
                lat_ph = 2;
            end else if (gt && !q_open && in_trk && lat_ph == 2) begin
                emit_trimmed(0);
                vlen[0] = 0; lat_ph = 0; lat_nl = 0;
            end
            // longitude
            lon_open = !q_open && in_trk && lon_ph == 0 && !in_ele && !in_time;
            if (!ws && !eq && lon_open) begin
                if (lon_nl < NDEPTH) begin lon_nm[lon_nl] = b; lon_nl++; end
            end else if ((ws || eq) && lon_open && lon_nl > 0) begin
                nm = new[NDEPTH];
                foreach (lon_nm[i]) nm[i] = lon_nm[i];
                if (matches_name(nm, lon_nl, "lon")) lon_ph = 1;
                lon_nl = 0;
            end else if ((q || q_open) && in_trk && lon_ph == 1) begin
                put_val(1, b);
            end else if ((ws || gt) && !q_open && in_trk && lon_ph == 1 && vlen[1] > 0) begin
                lon_ph = 2;
            end
            if (gt && !q_open && in_trk && lon_ph == 2) begin
                emit_trimmed(1);
                vlen[1] = 0; lon_ph = 0; lon_nl = 0;
            end
            // elevation text
            if (gt && !q_open && in_trk && in_ele) begin
                ele_pos = 1;
            end else if (!lt && ele_pos) begin
                put_val(2, b);
            end else if (lt && ele_pos) begin
                ele_pos = 0;
            end else if ((ws || gt) && in_trk && !in_ele && vlen[2] > 0) begin
                for (int i = 0; i < vlen[2]; i++) push(vals[2][i], 0);
                push(",", 0);
                vlen[2] = 0;
            end
            // time text, commas flagged
            if (gt && !q_open && in_trk && in_time) begin
                tm_pos = 1;
            end else if (!lt && tm_pos) begin
                put_val(3, b);
            end else if (lt && tm_pos) begin
                tm_pos = 0;
            end else if ((ws || gt) && in_trk && !in_time && vlen[3] > 0) begin
                for (int i = 0; i < vlen[3]; i++)
                    push(vals[3][i], vals[3][i] == ",");
                push(8'h0a, 0);
                vlen[3] = 0;
            end
            if (burst.size() > 0) burst[burst.size() - 1].last = 1;
            foreach (burst[i]) pending.push_back(burst[i]);
        endfunction

        function void check_byte(t_csv_byte got);
            t_csv_byte want;
            if (pending.size() == 0) begin
                $error("unexpected item: out_char=%0h esc=%0b last=%0b",
                       got.ch, got.esc, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.ch !== want.ch) begin
                $error("out_char: expected %0h, got %0h", want.ch, got.ch); errors++;
            end
            if (got.esc !== want.esc) begin
                $error("escape_comma: expected %0b, got %0b", want.esc, got.esc); errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last); errors++;
            end
        endfunction
    endclass

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_valid = 0;
    logic       o_stall;
    logic [7:0] i_in_char = 0;
    logic       o_valid;
    logic       i_stall = 1;
    logic [7:0] o_out_char;
    logic       o_escape_comma;
    logic       o_last;

    t_scoreboard sb = new();
    bit hold_off = 0;
    bit stim_done = 0;
    int sent = 0;

    always #4 i_clk = ~i_clk;

    gpx_trackpoint_csv_extractor_unit i_dut (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // send one GPX character, then maybe idle
    task automatic send_char(logic [7:0] c);
        int g;
        i_valid <= 1;
        i_in_char <= c;
        do @(posedge i_clk); while (o_stall);
        sb.note_char(c);
        sent++;
        g = hold_off ? 0 : gap_len();
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_str(string s);
        foreach (s[i]) send_char(s[i]);
    endtask

    function automatic string rand_case(string s);
        string r = s;
        foreach (r[i])
            if ($urandom_range(0, 1) && r[i] >= "A" && r[i] <= "Z") r[i] = r[i] + 8'd32;
        return r;
    endfunction

    function automatic string rand_text(int n, bit commas);
        string r = "";
        byte c;
        for (int i = 0; i < n; i++) begin
            c = commas && $urandom_range(0, 3) == 0 ? "," : 8'($urandom_range(48, 57));
            if ($urandom_range(0, 9) == 0) c = ".";
            r = {r, string'(c)};
        end
        return r;
    endfunction

    // one track point with random content and structure variations
    task automatic send_trkpt();
        string qc, sep;
        qc = $urandom_range(0, 1) ? "\"" : "'";
        sep = $urandom_range(0, 3) == 0 ? "\t" : " ";
        send_str({"<", rand_case("trkpt")});
        if ($urandom_range(0, 1)) begin
            send_str({sep, rand_case("lat"), "=", qc, rand_text($urandom_range(0, 30), 0), qc});
            send_str({sep, rand_case("lon"), "=", qc, rand_text($urandom_range(0, 12), 0), qc});
        end else begin
            send_str({sep, rand_case("lon"), "=", qc, rand_text($urandom_range(0, 12), 0), qc});
            send_str({sep, rand_case("lat"), "=", qc, rand_text($urandom_range(0, 12), 0), qc});
        end
        send_str(">\n");
        if ($urandom_range(0, 3) != 0)
            send_str({"<", rand_case("ele"), ">", rand_text($urandom_range(0, 28), 0),
                      "</", rand_case("ele"), ">\n"});
        if ($urandom_range(0, 3) != 0)
            send_str({"<", rand_case("time"), ">", rand_text($urandom_range(0, 28), 1),
                      "</", rand_case("time"), ">\n"});
        send_str({"</", rand_case("trkpt"), ">\n"});
    endtask

    // result side: random stalls, plus the long hold-off when asked
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_byte('{o_out_char, o_escape_comma, o_last});
        if (!i_rst_n) i_stall <= 1;
        else if (hold_off) i_stall <= 1;
        else i_stall <= ($urandom_range(0, 99) < 25);
    end

    // sender
    initial begin
        string noise;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: canonical point, case mix, overflow, quote oddities, zero byte
        send_str("<trkpt lat=\"45.1\" lon=\"7.2\">\n<ele>123</ele>\n");
        send_str("<time>2020-01-01T00:00:00Z,x</time></trkpt>\n");
        send_str("<TrKpT LAT='1' LoN=''><ELE>abcdefghijklmnopqrstuvwxyz0123</EleX ></ElE>");
        send_str("<TIMe>a,,b</time\t></TRKPT\r>");
        send_str("<trkptx lat=\"9\"> <> < trkpt lat=\"5\">");
        send_char(8'h00); send_char(8'hff); send_char(8'h0b); send_char(8'h0c);
        // pressure: receiver holds off while the sender keeps going
        hold_off = 1;
        fork
            begin repeat (400) @(posedge i_clk); hold_off = 0; end
            send_trkpt();
        join
        while (sent < 500) begin
            if ($urandom_range(0, 9) < 8) begin
                send_trkpt();
            end else begin
                noise = "";
                repeat ($urandom_range(1, 10)) noise = {noise, string'(byte'($urandom_range(0, 255)))};
                send_str(noise);
            end
        end
        i_valid <= 0;
        stim_done = 1;
    end

    // end of run
    initial begin
        wait (stim_done);
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/gpx_pkg.sv
hw/rtl/gpx_ctrl.sv
hw/rtl/gpx_dp.sv
hw/rtl/gpx_trackpoint_csv_extractor_unit.sv
tb/tb_top.sv
